// File: sv/hhgw_pkg.sv
package hhgw_pkg;

    localparam int LEVEL_WIDTH_DEF = 8;
    localparam int CFG_W           = 8;
    localparam int OUT_W           = 8;
    localparam int IN_DATA_W       = 8;
    localparam int OUT_DATA_W      = 64;
    localparam int ANGLE_W         = 15;
    localparam int FRAC_W          = 17;
    localparam int QUO_W           = 16;
    localparam int STEP_W          = 4;

    localparam logic [CFG_W-1:0] MAX_LEVEL_RST = 8'd5;

    // Highest quotient bit for each division: ring/max_level stays below 1.0 in Q0.16,
    // and 3840*x/ring stays below 4096 since x never exceeds the ring.
    localparam logic [STEP_W-1:0] FRAC_TOP = 4'd15;
    localparam logic [STEP_W-1:0] ANG_TOP  = 4'd11;

    localparam logic [FRAC_W-1:0]  FRAC_ONE    = 17'd65536;
    localparam logic [ANGLE_W-1:0] ANG_RED     = 15'd0;
    localparam logic [ANGLE_W-1:0] ANG_GREEN   = 15'd7680;
    localparam logic [ANGLE_W-1:0] ANG_BLUE    = 15'd15360;
    localparam logic [ANGLE_W-1:0] ANG_RED_TOP = 15'd23040;

    localparam logic OP_MOVE   = 1'b0;
    localparam logic OP_CENTER = 1'b1;

    localparam logic [2:0] DIR_NONE    = 3'd0;
    localparam logic [2:0] DIR_RED     = 3'd1;
    localparam logic [2:0] DIR_YELLOW  = 3'd2;
    localparam logic [2:0] DIR_GREEN   = 3'd3;
    localparam logic [2:0] DIR_CYAN    = 3'd4;
    localparam logic [2:0] DIR_BLUE    = 3'd5;
    localparam logic [2:0] DIR_MAGENTA = 3'd6;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MOVE,
        ST_RING,
        ST_FRAC_GO,
        ST_FRAC_RUN,
        ST_ANG_GO,
        ST_ANG_RUN,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic load_in;
        logic do_move;
        logic calc_ring;
        logic div_start;
        logic div_frac;
        logic take_frac;
        logic take_angle;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic ring_zero;
        logic frac_sat;
        logic ang_needed;
        logic div_done;
        logic out_free;
    } t_stat;

endpackage

// File: sv/hex_hue_grid_walker_top.sv
// Hex hue grid walker.
// Keeps a red/green/blue position on a hexagonal hue grid. Each request on the
// slave stream either re-centers the position (tuser = 1) or moves it one cell
// toward the direction in tdata[2:0] (0 none, 1 red .. 6 magenta), clamped at
// max_level. Every request yields one result on the master stream: the three
// levels, the ring, the hue angle (degrees, 6 fraction bits) and ring/max_level
// in Q1.16, packed in tdata as listed at the port.
// max_level is written through i_cfg_we/i_cfg_wdata; write it only while idle.
// One request is in work at a time. When used, the shared serial divider takes
// 16 steps for the fraction and 12 for the angle, one quotient bit per cycle.
// The next request can be taken as soon as the result is in the output
// register, even if the receiver has not yet taken it.
// A stalled receiver holds the result; a later request then waits in the
// final stage until the output register frees up.
// Reset clears the position to the center and sets max_level to 5.
module hex_hue_grid_walker_top #(
    parameter int LEVEL_WIDTH = hhgw_pkg::LEVEL_WIDTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [hhgw_pkg::CFG_W-1:0]        i_cfg_wdata,
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    // [2:0] direction, [7:3] zero
    input  logic [hhgw_pkg::IN_DATA_W-1:0]    i_s_tdata,
    // [0] operation
    input  logic                              i_s_tuser,
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    // [7:0] red_out, [15:8] green_out, [23:16] blue_out, [31:24] ring_level,
    // [46:32] hue_angle, [63:47] effect_fraction
    output logic [hhgw_pkg::OUT_DATA_W-1:0]   o_m_tdata
);

    hhgw_pkg::t_cmd  cmd;
    hhgw_pkg::t_stat stat;

    hhgw_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    hhgw_dp #(
        .LEVEL_WIDTH (LEVEL_WIDTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_op        (i_s_tuser),
        .i_dir       (i_s_tdata[2:0]),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata)
    );

endmodule

// File: sv/hhgw_div.sv
module hhgw_div #(
    parameter int DVW = hhgw_pkg::CFG_W
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [hhgw_pkg::STEP_W-1:0]   i_top,
    input  logic [DVW+hhgw_pkg::QUO_W-1:0] i_dividend,
    input  logic [DVW-1:0]                i_divisor,
    output logic [hhgw_pkg::QUO_W-1:0]    o_quo,
    output logic                          o_rem_nz,
    output logic                          o_done
);

    localparam int DW = DVW + hhgw_pkg::QUO_W;

    logic [DW-1:0]                r_rem, n_rem;
    logic [DW-1:0]                r_dsh, n_dsh;
    logic [hhgw_pkg::QUO_W-1:0]   r_quo, n_quo;
    logic [hhgw_pkg::STEP_W-1:0]  r_k, n_k;
    logic                         r_busy, n_busy;
    logic                         r_done, n_done;
    logic                         fits;

    assign fits = (r_rem >= r_dsh);

    always_comb begin
        n_rem  = r_rem;
        n_dsh  = r_dsh;
        n_quo  = r_quo;
        n_k    = r_k;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_start) begin
            n_rem  = i_dividend;
            n_dsh  = DW'(i_divisor) << i_top;
            n_quo  = '0;
            n_k    = i_top;
            n_busy = 1'b1;
        end else if (r_busy) begin
            // one quotient bit per cycle, restoring form
            if (fits) begin
                n_rem = r_rem - r_dsh;
            end
            n_quo = {r_quo[hhgw_pkg::QUO_W-2:0], fits};
            n_dsh = r_dsh >> 1;
            n_k   = r_k - 1'b1;
            if (r_k == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_rem <= n_rem;
        r_dsh <= n_dsh;
        r_quo <= n_quo;
        r_k   <= n_k;
    end

    assign o_quo    = r_quo;
    assign o_rem_nz = (r_rem != '0);
    assign o_done   = r_done;

endmodule

// File: sv/hhgw_dp.sv
module hhgw_dp #(
    parameter int LEVEL_WIDTH = hhgw_pkg::LEVEL_WIDTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [hhgw_pkg::CFG_W-1:0]        i_cfg_wdata,
    input  logic                              i_op,
    input  logic [2:0]                        i_dir,
    input  hhgw_pkg::t_cmd                    i_cmd,
    output hhgw_pkg::t_stat                   o_stat,
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    output logic [hhgw_pkg::OUT_DATA_W-1:0]   o_m_tdata
);

    localparam int DVW = (LEVEL_WIDTH > hhgw_pkg::CFG_W) ? LEVEL_WIDTH : hhgw_pkg::CFG_W;
    localparam int DW  = DVW + hhgw_pkg::QUO_W;
    localparam logic [DVW-1:0] LEVEL_MASK = DVW'({LEVEL_WIDTH{1'b1}});

    typedef enum logic [1:0] {MODE_NONE, MODE_NEXT, MODE_PREV} t_mode;
    typedef enum logic [1:0] {HUE_RED, HUE_GREEN, HUE_BLUE} t_hue;

    logic [hhgw_pkg::CFG_W-1:0] r_max_level;
    logic                       r_op;
    logic [2:0]                 r_dir;
    logic [LEVEL_WIDTH-1:0]     r_red, r_green, r_blue;
    logic [LEVEL_WIDTH-1:0]     n_red, n_green, n_blue;
    logic [LEVEL_WIDTH-1:0]     r_ring, n_ring;
    logic [LEVEL_WIDTH-1:0]     r_x, n_x;
    t_mode                      r_mode, n_mode;
    t_hue                       r_hue, n_hue;
    logic                       r_sat;
    logic [hhgw_pkg::QUO_W-1:0] r_frac_q;
    logic [hhgw_pkg::QUO_W-1:0] r_ang_q;
    logic                       r_ang_rnz;
    logic                       r_tvalid;
    logic [hhgw_pkg::OUT_DATA_W-1:0] r_tdata;

    logic [LEVEL_WIDTH-1:0]     cap;
    logic [DVW-1:0]             max_ext;
    logic [LEVEL_WIDTH-1:0]     a, b, c, na, nb, nc;
    logic                       primary, valid_dir;
    logic [LEVEL_WIDTH-1:0]     nxt, prv;

    logic [DW-1:0]              x_ext;
    logic [DW-1:0]              div_dividend;
    logic [DVW-1:0]             div_divisor;
    logic [hhgw_pkg::QUO_W-1:0] div_quo;
    logic                       div_rem_nz;
    logic                       div_done;

    logic [hhgw_pkg::ANGLE_W-1:0] base_ang, wrap_ang, q_ang, angle;
    logic [hhgw_pkg::FRAC_W-1:0]  frac;

    assign max_ext = DVW'(r_max_level);
    assign cap     = (max_ext > LEVEL_MASK) ? LEVEL_MASK[LEVEL_WIDTH-1:0]
                                            : max_ext[LEVEL_WIDTH-1:0];

    // Move: pick the three roles for the direction, step, then map back; a center request clears all three levels.
    always_comb begin
        a = r_red;
        b = r_green;
        c = r_blue;
        primary   = 1'b1;
        valid_dir = 1'b1;
        case (r_dir)
            hhgw_pkg::DIR_RED:     begin a = r_red;   b = r_green; c = r_blue;  primary = 1'b1; end
            hhgw_pkg::DIR_YELLOW:  begin a = r_blue;  b = r_red;   c = r_green; primary = 1'b0; end
            hhgw_pkg::DIR_GREEN:   begin a = r_green; b = r_red;   c = r_blue;  primary = 1'b1; end
            hhgw_pkg::DIR_CYAN:    begin a = r_red;   b = r_blue;  c = r_green; primary = 1'b0; end
            hhgw_pkg::DIR_BLUE:    begin a = r_blue;  b = r_red;   c = r_green; primary = 1'b1; end
            hhgw_pkg::DIR_MAGENTA: begin a = r_green; b = r_red;   c = r_blue;  primary = 1'b0; end
            default:               valid_dir = 1'b0;
        endcase

        na = a;
        nb = b;
        nc = c;
        if (primary) begin
            if (b == '0 || c == '0) begin
                if (a < cap) begin
                    na = a + 1'b1;
                end else begin
                    if (b != '0) nb = b - 1'b1;
                    if (c != '0) nc = c - 1'b1;
                end
            end else begin
                nb = b - 1'b1;
                nc = c - 1'b1;
            end
        end else begin
            if (a != '0) begin
                na = a - 1'b1;
            end else begin
                if (b < cap) nb = b + 1'b1;
                if (c < cap) nc = c + 1'b1;
            end
        end

        n_red   = r_red;
        n_green = r_green;
        n_blue  = r_blue;
        if (r_op == hhgw_pkg::OP_CENTER) begin
            n_red   = '0;
            n_green = '0;
            n_blue  = '0;
        end else if (valid_dir) begin
            case (r_dir)
                hhgw_pkg::DIR_RED:     begin n_red = na;   n_green = nb; n_blue = nc;  end
                hhgw_pkg::DIR_YELLOW:  begin n_blue = na;  n_red = nb;   n_green = nc; end
                hhgw_pkg::DIR_GREEN:   begin n_green = na; n_red = nb;   n_blue = nc;  end
                hhgw_pkg::DIR_CYAN:    begin n_red = na;   n_blue = nb;  n_green = nc; end
                hhgw_pkg::DIR_BLUE:    begin n_blue = na;  n_red = nb;   n_green = nc; end
                hhgw_pkg::DIR_MAGENTA: begin n_green = na; n_red = nb;   n_blue = nc;  end
                default:               n_red = r_red;
            endcase
        end
    end

    // Ring, leading primary and the neighbor level that bends the angle.
    always_comb begin
        n_ring = r_red;
        if (r_green > n_ring) n_ring = r_green;
        if (r_blue > n_ring)  n_ring = r_blue;

        if (r_red == n_ring) begin
            n_hue = HUE_RED;   nxt = r_green; prv = r_blue;
        end else if (r_green == n_ring) begin
            n_hue = HUE_GREEN; nxt = r_blue;  prv = r_red;
        end else begin
            n_hue = HUE_BLUE;  nxt = r_red;   prv = r_green;
        end

        if (nxt != '0) begin
            n_mode = MODE_NEXT; n_x = nxt;
        end else if (prv != '0) begin
            n_mode = MODE_PREV; n_x = prv;
        end else begin
            n_mode = MODE_NONE; n_x = '0;
        end
    end

    // 3840 * x as (x << 12) - (x << 8)
    assign x_ext        = DW'(r_x);
    assign div_dividend = i_cmd.div_frac ? {DVW'(r_ring), {hhgw_pkg::QUO_W{1'b0}}}
                                         : (x_ext << 12) - (x_ext << 8);
    assign div_divisor  = i_cmd.div_frac ? max_ext : DVW'(r_ring);

    hhgw_div #(
        .DVW (DVW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_top      (i_cmd.div_frac ? hhgw_pkg::FRAC_TOP : hhgw_pkg::ANG_TOP),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_quo      (div_quo),
        .o_rem_nz   (div_rem_nz),
        .o_done     (div_done)
    );

    // Result assembly; a zero ring lands on red with no neighbor, giving angle 0.
    always_comb begin
        case (r_hue)
            HUE_GREEN: begin base_ang = hhgw_pkg::ANG_GREEN; wrap_ang = hhgw_pkg::ANG_GREEN;   end
            HUE_BLUE:  begin base_ang = hhgw_pkg::ANG_BLUE;  wrap_ang = hhgw_pkg::ANG_BLUE;    end
            default:   begin base_ang = hhgw_pkg::ANG_RED;   wrap_ang = hhgw_pkg::ANG_RED_TOP; end
        endcase
        q_ang = r_ang_q[hhgw_pkg::ANGLE_W-1:0];
        case (r_mode)
            MODE_NEXT: angle = base_ang + q_ang;
            MODE_PREV: angle = wrap_ang - q_ang - hhgw_pkg::ANGLE_W'(r_ang_rnz);
            default:   angle = base_ang;
        endcase
        frac = r_sat ? hhgw_pkg::FRAC_ONE : hhgw_pkg::FRAC_W'(r_frac_q);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_level <= hhgw_pkg::MAX_LEVEL_RST;
            r_red       <= '0;
            r_green     <= '0;
            r_blue      <= '0;
            r_tvalid    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_max_level <= i_cfg_wdata;
            end
            if (i_cmd.do_move) begin
                r_red   <= n_red;
                r_green <= n_green;
                r_blue  <= n_blue;
            end
            if (i_cmd.emit) begin
                r_tvalid <= 1'b1;
            end else if (i_m_tready) begin
                r_tvalid <= 1'b0;
            end
        end

        if (i_cmd.load_in) begin
            r_op  <= i_op;
            r_dir <= i_dir;
        end
        if (i_cmd.calc_ring) begin
            r_ring   <= n_ring;
            r_hue    <= n_hue;
            r_mode   <= n_mode;
            r_x      <= n_x;
            // a zero ring reports a zero fraction, even with max_level 0
            r_sat    <= (n_ring != '0) &&
                        ((max_ext == '0) || (DVW'(n_ring) >= max_ext));
            r_frac_q <= '0;
            r_ang_q  <= '0;
            r_ang_rnz <= 1'b0;
        end
        if (i_cmd.take_frac) begin
            r_frac_q <= div_quo;
        end
        if (i_cmd.take_angle) begin
            r_ang_q   <= div_quo;
            r_ang_rnz <= div_rem_nz;
        end
        if (i_cmd.emit) begin
            r_tdata <= {frac, angle,
                        hhgw_pkg::OUT_W'(r_ring),
                        hhgw_pkg::OUT_W'(r_blue),
                        hhgw_pkg::OUT_W'(r_green),
                        hhgw_pkg::OUT_W'(r_red)};
        end
    end

    assign o_stat.ring_zero  = (r_ring == '0);
    assign o_stat.frac_sat   = r_sat;
    assign o_stat.ang_needed = (r_mode != MODE_NONE);
    assign o_stat.div_done   = div_done;
    assign o_stat.out_free   = !r_tvalid || i_m_tready;

    assign o_m_tvalid = r_tvalid;
    assign o_m_tdata  = r_tdata;

endmodule

// File: sv/hhgw_ctrl.sv
module hhgw_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_s_tvalid,
    output logic            o_s_tready,
    input  hhgw_pkg::t_stat i_stat,
    output hhgw_pkg::t_cmd  o_cmd
);

    hhgw_pkg::t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        case (r_state)
            hhgw_pkg::ST_IDLE:     if (i_s_tvalid) n_state = hhgw_pkg::ST_MOVE;
            hhgw_pkg::ST_MOVE:     n_state = hhgw_pkg::ST_RING;
            hhgw_pkg::ST_RING:     n_state = hhgw_pkg::ST_FRAC_GO;
            hhgw_pkg::ST_FRAC_GO: begin
                if (i_stat.ring_zero) begin
                    n_state = hhgw_pkg::ST_EMIT;
                end else if (i_stat.frac_sat) begin
                    n_state = hhgw_pkg::ST_ANG_GO;
                end else begin
                    n_state = hhgw_pkg::ST_FRAC_RUN;
                end
            end
            hhgw_pkg::ST_FRAC_RUN: if (i_stat.div_done) n_state = hhgw_pkg::ST_ANG_GO;
            hhgw_pkg::ST_ANG_GO:   n_state = i_stat.ang_needed ? hhgw_pkg::ST_ANG_RUN
                                                               : hhgw_pkg::ST_EMIT;
            hhgw_pkg::ST_ANG_RUN:  if (i_stat.div_done) n_state = hhgw_pkg::ST_EMIT;
            hhgw_pkg::ST_EMIT:     if (i_stat.out_free) n_state = hhgw_pkg::ST_IDLE;
            default:               n_state = hhgw_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_s_tready = 1'b0;
        case (r_state)
            hhgw_pkg::ST_IDLE: begin
                o_s_tready    = 1'b1;
                o_cmd.load_in = i_s_tvalid;
            end
            hhgw_pkg::ST_MOVE:  o_cmd.do_move   = 1'b1;
            hhgw_pkg::ST_RING:  o_cmd.calc_ring = 1'b1;
            hhgw_pkg::ST_FRAC_GO: begin
                o_cmd.div_frac  = 1'b1;
                o_cmd.div_start = !i_stat.ring_zero && !i_stat.frac_sat;
            end
            hhgw_pkg::ST_FRAC_RUN: begin
                o_cmd.div_frac  = 1'b1;
                o_cmd.take_frac = i_stat.div_done;
            end
            hhgw_pkg::ST_ANG_GO:  o_cmd.div_start  = i_stat.ang_needed;
            hhgw_pkg::ST_ANG_RUN: o_cmd.take_angle = i_stat.div_done;
            hhgw_pkg::ST_EMIT:    o_cmd.emit       = i_stat.out_free;
            default:              o_cmd = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= hhgw_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule
